// ===== rtl/pud_pkg.sv =====
package pud_pkg;

    localparam int PAGES_PER_BLOCK = 64;
    localparam int NUM_BLOCKS      = 1024;
    localparam int OFF_W           = $clog2(PAGES_PER_BLOCK);
    localparam int BLK_W           = $clog2(NUM_BLOCKS);
    localparam int ADDR_W          = 16;
    localparam int CNT_W           = BLK_W + 1;
    localparam int OCC_W           = 17;
    localparam int WC_W            = 32;
    localparam int DC_W            = 7;
    localparam int PCT_W           = 7;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 17;

    localparam logic [DC_W-1:0]  DC_MAX     = 7'd127;
    localparam logic [OCC_W-1:0] OCC_MAX    = 17'h1FFFF;
    localparam logic [OCC_W-1:0] OCC_LIMIT  = 17'd65536;

    // floor(x / 100) == (x * RECIP_K) >> RECIP_SH for every x below 199728
    localparam logic [17:0] RECIP_K  = 18'd167773;
    localparam int          RECIP_SH = 24;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAGES      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_PERCENT = 1'b1;

    typedef struct packed {
        logic                 is_write;
        logic [BLK_W-1:0]     blk;
        logic [OFF_W-1:0]     off;
        logic [WC_W-1:0]      wc;
    } item_t;

    typedef struct packed {
        logic                       bvalid;
        logic [DC_W-1:0]            dcount;
        logic [31:0]                hits;
        logic [31:0]                ud;
        logic [31:0]                lw;
        logic [PAGES_PER_BLOCK-1:0] pvalid;
        logic [PAGES_PER_BLOCK-1:0] pdirty;
    } row_t;

    typedef struct packed {
        logic [BLK_W-1:0] idx;
        logic [DC_W-1:0]  dcount;
        logic             gt1;
    } cand_t;

endpackage

// ===== rtl/pud_if.sv =====
interface pud_access_if import pud_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [ADDR_W-1:0] page_addr;

    modport source (output valid, cmd, page_addr, input ready);
    modport sink   (input valid, cmd, page_addr, output ready);
endinterface

interface pud_result_if import pud_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic                       evicted;
    logic [BLK_W-1:0]           victim_block;
    logic [PAGES_PER_BLOCK-1:0] dirty_mask;

    modport source (output valid, hit, evicted, victim_block, dirty_mask, input ready);
    modport sink   (input valid, hit, evicted, victim_block, dirty_mask, output ready);
endinterface

// ===== rtl/pud_fifo.sv =====
module pud_fifo import pud_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_data,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_data
);

    item_t       mem_reg [2];
    logic        wp_reg, wp_next;
    logic        rp_reg, rp_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        do_push, do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = mem_reg[rp_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/pud_front.sv =====
module pud_front import pud_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    pud_access_if.sink   access,
    input  logic         clearing,
    output logic         push_valid,
    input  logic         push_ready,
    output item_t        push_data
);

    logic [WC_W-1:0] wc_reg, wc_next;
    logic            is_write;

    assign is_write     = (access.cmd == CMD_WRITE);
    assign access.ready = push_ready && !clearing;
    assign push_valid   = access.valid && !clearing;

    // every write advances the update counter; the word carries its value
    always_comb
    begin
        wc_next = wc_reg;
        if (access.valid && access.ready && is_write)
        begin
            wc_next = wc_reg + 32'd1;
        end
        push_data.is_write = is_write;
        push_data.blk      = access.page_addr[ADDR_W-1:OFF_W];
        push_data.off      = access.page_addr[OFF_W-1:0];
        push_data.wc       = is_write ? wc_reg + 32'd1 : wc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg <= '0;
        end
        else
        begin
            wc_reg <= wc_next;
        end
    end

endmodule

// ===== rtl/pud_back.sv =====
module pud_back import pud_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  item_t                 pop_data,
    output logic                  clearing,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    pud_result_if.source          result
);

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_RD   = 5'd2;
    localparam logic [4:0] S_MUL  = 5'd3;
    localparam logic [4:0] S_ADD  = 5'd4;
    localparam logic [4:0] S_DIV  = 5'd5;
    localparam logic [4:0] S_HIT  = 5'd6;
    localparam logic [4:0] S_SCAN = 5'd7;
    localparam logic [4:0] S_F1   = 5'd8;
    localparam logic [4:0] S_F2   = 5'd9;
    localparam logic [4:0] S_LIM  = 5'd10;
    localparam logic [4:0] S_OI   = 5'd11;
    localparam logic [4:0] S_OL   = 5'd12;
    localparam logic [4:0] S_IN   = 5'd13;
    localparam logic [4:0] S_OE   = 5'd14;
    localparam logic [4:0] S_EV   = 5'd15;
    localparam logic [4:0] S_EV2  = 5'd16;
    localparam logic [4:0] S_INS  = 5'd17;
    localparam logic [4:0] S_OUT  = 5'd18;

    localparam logic [CNT_W-1:0] NB = CNT_W'(NUM_BLOCKS);

    function automatic logic [OFF_W:0] popcount(input logic [PAGES_PER_BLOCK-1:0] v);
        logic [OFF_W:0] c;
        c = '0;
        for (int k = 0; k < PAGES_PER_BLOCK; k++)
        begin
            c = c + {{OFF_W{1'b0}}, v[k]};
        end
        return c;
    endfunction

    // block state and candidate list memories
    row_t  smem [NUM_BLOCKS];
    row_t  smem_q;
    logic  sw_en;
    logic [BLK_W-1:0] sw_addr, sr_addr;
    row_t  sw_data;

    cand_t cmem [NUM_BLOCKS];
    cand_t cmem_q;
    logic  cw_en;
    logic [BLK_W-1:0] cw_addr, cr_addr;
    cand_t cw_data;

    always_ff @(posedge clk)
    begin
        if (sw_en)
        begin
            smem[sw_addr] <= sw_data;
        end
        smem_q <= smem[sr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cw_en)
        begin
            cmem[cw_addr] <= cw_data;
        end
        cmem_q <= cmem[cr_addr];
    end

    logic [4:0]            state_reg, state_next;
    logic [BLK_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [OCC_W-1:0]      occ_reg, occ_next;
    logic [OCC_W-1:0]      max_pages_reg;
    logic [PCT_W-1:0]      pct_reg;
    logic                  out_v_reg, out_v_next;

    item_t                 item_reg, item_next;
    row_t                  row_reg, row_next;
    logic [63:0]           prod_reg, prod_next;
    logic [63:0]           num_reg, num_next;
    logic [31:0]           rem_reg, rem_next;
    logic [32:0]           dvs_reg, dvs_next;
    logic [5:0]            div_cnt_reg, div_cnt_next;
    logic [CNT_W-1:0]      scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [OCC_W-1:0]      np_reg, np_next;
    logic [CNT_W-1:0]      f_reg, f_next;
    logic [CNT_W-1:0]      lim_reg, lim_next;
    logic [CNT_W-1:0]      i_reg, i_next;
    logic [CNT_W-1:0]      j_reg, j_next;
    cand_t                 held_reg, held_next;
    logic [BLK_W-1:0]      e0_reg, e0_next;
    logic [BLK_W-1:0]      victim_reg, victim_next;
    logic                  hit_reg, hit_next;
    logic                  ev_reg, ev_next;
    logic [PAGES_PER_BLOCK-1:0] mask_reg, mask_next;

    logic                  out_hit_reg, out_ev_reg;
    logic [BLK_W-1:0]      out_vic_reg;
    logic [PAGES_PER_BLOCK-1:0] out_mask_reg;
    logic                  out_load;

    logic [32:0]           rem_sh;
    logic                  rem_ge;
    logic [31:0]           gap;
    logic [31:0]           rd_dist;
    logic [32:0]           pud_sum;
    logic [34:0]           f_prod;
    logic [CNT_W:0]        f_inc;
    logic [OFF_W:0]        vcnt;
    row_t                  r;

    assign clearing       = (state_reg == S_CLR);
    assign pop_ready      = (state_reg == S_IDLE);
    assign result.valid        = out_v_reg;
    assign result.hit          = out_hit_reg;
    assign result.evicted      = out_ev_reg;
    assign result.victim_block = out_vic_reg;
    assign result.dirty_mask   = out_mask_reg;

    assign rem_sh  = {rem_reg, num_reg[63]};
    assign rem_ge  = (rem_sh >= dvs_reg);
    assign gap     = item_reg.wc - row_reg.lw - 32'd1;
    assign rd_dist = item_reg.wc - smem_q.lw;
    assign pud_sum = {1'b0, smem_q.ud} + {1'b0, rd_dist};
    assign f_prod  = 35'(np_reg) * 35'(RECIP_K);
    assign f_inc   = {1'b0, f_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign vcnt    = popcount(smem_q.pvalid);

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        occ_next      = occ_reg;
        out_v_next    = out_v_reg;
        item_next     = item_reg;
        row_next      = row_reg;
        prod_next     = prod_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        dvs_next      = dvs_reg;
        div_cnt_next  = div_cnt_reg;
        scan_cnt_next = scan_cnt_reg;
        n_next        = n_reg;
        np_next       = np_reg;
        f_next        = f_reg;
        lim_next      = lim_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        held_next     = held_reg;
        e0_next       = e0_reg;
        victim_next   = victim_reg;
        hit_next      = hit_reg;
        ev_next       = ev_reg;
        mask_next     = mask_reg;
        out_load      = 1'b0;
        r             = row_reg;

        sw_en   = 1'b0;
        sw_addr = item_reg.blk;
        sw_data = row_reg;
        sr_addr = item_reg.blk;
        cw_en   = 1'b0;
        cw_addr = i_reg[BLK_W-1:0];
        cw_data = held_reg;
        cr_addr = i_reg[BLK_W-1:0];

        if (out_v_reg && result.ready)
        begin
            out_v_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR:
            begin
                sw_en        = 1'b1;
                sw_addr      = clr_cnt_reg;
                sw_data      = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == BLK_W'(NUM_BLOCKS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                sr_addr = pop_data.blk;
                if (pop_valid)
                begin
                    item_next  = pop_data;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                row_next = smem_q;
                if (item_reg.is_write && smem_q.bvalid)
                begin
                    row_next.hits = smem_q.hits + 32'd1;
                    state_next    = S_MUL;
                end
                else
                begin
                    state_next = S_HIT;
                end
            end
            S_MUL:
            begin
                prod_next  = 64'(row_reg.ud) * 64'(row_reg.hits);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                num_next     = prod_reg + {32'd0, gap};
                rem_next     = '0;
                dvs_next     = {1'b0, row_reg.hits} + 33'd1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                // one quotient bit per cycle, restoring
                rem_next     = rem_ge ? 32'(rem_sh - dvs_reg) : rem_sh[31:0];
                num_next     = {num_reg[62:0], rem_ge};
                div_cnt_next = div_cnt_reg + 6'd1;
                if (div_cnt_reg == 6'd63)
                begin
                    row_next.ud = {num_reg[30:0], rem_ge};
                    row_next.lw = item_reg.wc;
                    state_next  = S_HIT;
                end
            end
            S_HIT:
            begin
                hit_next    = 1'b0;
                ev_next     = 1'b0;
                victim_next = '0;
                mask_next   = '0;
                sw_en       = 1'b1;
                if (row_reg.pvalid[item_reg.off])
                begin
                    hit_next = 1'b1;
                    if (item_reg.is_write)
                    begin
                        r.pdirty[item_reg.off] = 1'b1;
                    end
                    sw_data    = r;
                    row_next   = r;
                    state_next = S_OUT;
                end
                else if (occ_reg >= max_pages_reg)
                begin
                    scan_cnt_next = '0;
                    n_next        = '0;
                    state_next    = S_SCAN;
                end
                else
                begin
                    state_next = S_INS;
                end
            end
            S_SCAN:
            begin
                // read data arrives in the cycle after its address
                sr_addr       = scan_cnt_reg[BLK_W-1:0];
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg != '0 && smem_q.bvalid)
                begin
                    cw_en          = 1'b1;
                    cw_addr        = n_reg[BLK_W-1:0];
                    cw_data.idx    = BLK_W'(scan_cnt_reg - 1'b1);
                    cw_data.dcount = smem_q.dcount;
                    cw_data.gt1    = |pud_sum[32:2];
                    n_next         = n_reg + 1'b1;
                end
                if (scan_cnt_reg == NB)
                begin
                    state_next = (n_next == '0) ? S_INS : S_F1;
                end
            end
            S_F1:
            begin
                np_next    = OCC_W'(n_reg) * OCC_W'(pct_reg);
                state_next = S_F2;
            end
            S_F2:
            begin
                f_next     = f_prod[RECIP_SH +: CNT_W];
                state_next = S_LIM;
            end
            S_LIM:
            begin
                lim_next   = (f_inc > {1'b0, n_reg}) ? n_reg : f_inc[CNT_W-1:0];
                i_next     = '0;
                state_next = S_OI;
            end
            S_OI:
            begin
                cr_addr    = i_reg[BLK_W-1:0];
                state_next = S_OL;
            end
            S_OL:
            begin
                held_next = cmem_q;
                j_next    = i_reg + 1'b1;
                cr_addr   = BLK_W'(i_reg + 1'b1);
                state_next = ((i_reg + 1'b1) < n_reg) ? S_IN : S_OE;
            end
            S_IN:
            begin
                if (held_reg.dcount < cmem_q.dcount)
                begin
                    cw_en     = 1'b1;
                    cw_addr   = j_reg[BLK_W-1:0];
                    cw_data   = held_reg;
                    held_next = cmem_q;
                end
                cr_addr = BLK_W'(j_reg + 1'b1);
                j_next  = j_reg + 1'b1;
                if ((j_reg + 1'b1) == n_reg)
                begin
                    state_next = S_OE;
                end
            end
            S_OE:
            begin
                cw_en   = 1'b1;
                cw_addr = i_reg[BLK_W-1:0];
                cw_data = held_reg;
                if (i_reg == '0)
                begin
                    e0_next = held_reg.idx;
                end
                if (held_reg.gt1)
                begin
                    victim_next = held_reg.idx;
                    state_next  = S_EV;
                end
                else if ((i_reg + 1'b1) == lim_reg)
                begin
                    victim_next = (i_reg == '0) ? held_reg.idx : e0_reg;
                    state_next  = S_EV;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_OI;
                end
            end
            S_EV:
            begin
                sr_addr    = victim_reg;
                state_next = S_EV2;
            end
            S_EV2:
            begin
                mask_next = smem_q.pdirty;
                ev_next   = 1'b1;
                occ_next  = (occ_reg >= OCC_W'(vcnt)) ? occ_reg - OCC_W'(vcnt) : '0;
                sw_en     = 1'b1;
                sw_addr   = victim_reg;
                sw_data   = '0;
                if (victim_reg == item_reg.blk)
                begin
                    row_next = '0;
                end
                state_next = S_INS;
            end
            S_INS:
            begin
                if (!r.pvalid[item_reg.off] && occ_reg != OCC_MAX)
                begin
                    occ_next = occ_reg + 1'b1;
                end
                r.pvalid[item_reg.off] = 1'b1;
                r.bvalid               = 1'b1;
                if (item_reg.is_write)
                begin
                    r.pdirty[item_reg.off] = 1'b1;
                    if (r.dcount != DC_MAX)
                    begin
                        r.dcount = r.dcount + 1'b1;
                    end
                end
                sw_en      = 1'b1;
                sw_data    = r;
                row_next   = r;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_v_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    out_v_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            occ_reg       <= '0;
            out_v_reg     <= 1'b0;
            max_pages_reg <= OCC_LIMIT;
            pct_reg       <= 7'd5;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            occ_reg     <= occ_next;
            out_v_reg   <= out_v_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MAX_PAGES:      max_pages_reg <= cfg_data;
                    CFG_SELECT_PERCENT: pct_reg       <= cfg_data[PCT_W-1:0];
                    default:            pct_reg       <= pct_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        row_reg      <= row_next;
        prod_reg     <= prod_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        div_cnt_reg  <= div_cnt_next;
        scan_cnt_reg <= scan_cnt_next;
        n_reg        <= n_next;
        np_reg       <= np_next;
        f_reg        <= f_next;
        lim_reg      <= lim_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        held_reg     <= held_next;
        e0_reg       <= e0_next;
        victim_reg   <= victim_next;
        hit_reg      <= hit_next;
        ev_reg       <= ev_next;
        mask_reg     <= mask_next;
        if (out_load)
        begin
            out_hit_reg  <= hit_reg;
            out_ev_reg   <= ev_reg;
            out_vic_reg  <= victim_reg;
            out_mask_reg <= mask_reg;
        end
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_LIMIT)
        else $error("page occupancy above buffer size");

    a_no_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_ev_reg) |-> (out_vic_reg == '0 && out_mask_reg == '0))
        else $error("victim fields set without eviction");

    a_sort_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OI) |-> (i_reg < lim_reg && lim_reg <= n_reg))
        else $error("sort position beyond limit");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |=> (state_reg == S_DIV || state_reg == S_HIT))
        else $error("divider left early");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_hit_reg) |-> !out_ev_reg)
        else $error("hit with eviction");

endmodule

// ===== rtl/pud_lru_block_buffer_policy.sv =====
// Page write buffer with block-level PUD-LRU replacement. One result word per
// access word. After reset a clearing pass zeroes the block state memory;
// no access is taken until it ends. A write to a buffered block first
// updates the mean update distance (one multiply, an add and a 64-step
// divide). A miss on a full buffer scans all 1024 block rows (one per
// cycle), then ranks candidates by dirty count at one candidate-memory read
// per cycle, stopping at the first place whose PUD sum is at least four or
// at the place limit set by the select percentage. Up to two accesses queue
// ahead of the replacement engine.
module pud_lru_block_buffer_policy import pud_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    pud_access_if.sink            access,
    pud_result_if.source          result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic  push_valid, push_ready, pop_valid, pop_ready, clearing;
    item_t push_data, pop_data;

    pud_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .access     (access),
        .clearing   (clearing),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    pud_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    pud_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .clearing  (clearing),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule
